// ===== rtl/life_automaton_generation_step_defines.svh =====
// Assertion macros used by the life automaton controller RTL.
// Each macro expects the signals clk and arst_n to exist in the module that uses it.
`ifndef LIFE_AUTOMATON_GENERATION_STEP_DEFINES_SVH
`define LIFE_AUTOMATON_GENERATION_STEP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge out of reset.
`define LGS_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lgs assertion failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define LGS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lgs assertion failed");

`else

`define LGS_ASSERT_IMPL(name, ante, cons)
`define LGS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== rtl/lgs_pkg.sv =====
package lgs_pkg;

	// Largest grid side the cell memory holds.
	localparam int MAX_SIDE = 64;
	localparam int IDX_W = $clog2(MAX_SIDE);

	// Field widths of the ports.
	localparam int GRID_W = 7;
	localparam int COUNT_W = 4;
	localparam int POS_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	// Internal side width holds both the register value and MAX_SIDE.
	localparam int SIDE_W = (GRID_W > $clog2(MAX_SIDE + 1)) ? GRID_W : $clog2(MAX_SIDE + 1);

	// Request actions.
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_STEP  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_A = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_B = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIRTH     = 2'd3;

	// Cell codes. Bit zero set means the cell is live.
	localparam logic [1:0] CODE_DEAD  = 2'd0;
	localparam logic [1:0] CODE_ALIVE = 2'd1;
	localparam logic [1:0] CODE_DIED  = 2'd2;
	localparam logic [1:0] CODE_BORN  = 2'd3;

	// Result kinds loaded into the output register.
	localparam logic [1:0] RES_ZERO = 2'd0;
	localparam logic [1:0] RES_CODE = 2'd1;
	localparam logic [1:0] RES_DONE = 2'd2;

	typedef struct packed {
		logic [1:0]       action;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             alive_in;
	} op_t;

	typedef struct packed {
		logic [1:0] cell_code;
		logic       step_done;
	} res_t;

	// One memory row of cell codes.
	typedef logic [MAX_SIDE-1:0][1:0] row_codes_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       cell_write;
		logic       cell_read;
		logic       step_start;
		logic       step_prime;
		logic       step_row;
		logic       res_load;
		logic [1:0] res_kind;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic side_zero;
		logic last_row;
	} stat_t;

	// Next code of one cell from its own liveness and its live neighbor count.
	function automatic logic [1:0] next_code(
		input logic               live,
		input logic [COUNT_W-1:0] nbrs,
		input logic [COUNT_W-1:0] surv_a,
		input logic [COUNT_W-1:0] surv_b,
		input logic [COUNT_W-1:0] birth
	);
		logic [1:0] code;
		if (live) begin
			code = (nbrs == surv_a || nbrs == surv_b) ? CODE_ALIVE : CODE_DIED;
		end else begin
			code = (nbrs == birth) ? CODE_BORN : CODE_DEAD;
		end
		return code;
	endfunction

endpackage

// ===== rtl/lgs_dp.sv =====
module lgs_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lgs_pkg::op_t                   op,
	input  logic                           cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  lgs_pkg::ctl_t                  ctl,
	output lgs_pkg::stat_t                 stat,
	output lgs_pkg::res_t                  res
);
	import lgs_pkg::*;

	logic [GRID_W-1:0]  grid_side_q;
	logic [COUNT_W-1:0] surv_a_q;
	logic [COUNT_W-1:0] surv_b_q;
	logic [COUNT_W-1:0] birth_q;

	logic [SIDE_W-1:0]   side;
	logic [MAX_SIDE-1:0] col_in;
	logic                op_inside;

	row_codes_t          cell_mem_q [MAX_SIDE];
	logic [MAX_SIDE-1:0] row_vld_q;

	logic [SIDE_W-1:0]   rc_q;
	logic [SIDE_W:0]     la_addr;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_idx;
	logic                rd_in;
	row_codes_t          rd_data_q;
	logic                rd_ok_q;
	logic [MAX_SIDE-1:0] rd_live;
	logic [IDX_W-1:0]    col_q;

	logic [MAX_SIDE-1:0] prev_live_q;
	logic [MAX_SIDE-1:0] cur_live_q;
	row_codes_t          new_row;

	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	row_codes_t          wr_data;
	logic [MAX_SIDE-1:0] wr_mask;
	logic                wr_full;

	res_t                res_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= GRID_W'(64);
			surv_a_q    <= COUNT_W'(2);
			surv_b_q    <= COUNT_W'(3);
			birth_q     <= COUNT_W'(3);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_SIDE: grid_side_q <= cfg_data[GRID_W-1:0];
				REG_SURVIVE_A: surv_a_q <= cfg_data[COUNT_W-1:0];
				REG_SURVIVE_B: surv_b_q <= cfg_data[COUNT_W-1:0];
				REG_BIRTH:     birth_q <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Side in use is the register value clipped to the memory size.
	assign side = (SIDE_W'(grid_side_q) > SIDE_W'(MAX_SIDE)) ?
		SIDE_W'(MAX_SIDE) : SIDE_W'(grid_side_q);

	// Columns inside the grid.
	always_comb begin
		for (int i = 0; i < MAX_SIDE; i++) begin
			col_in[i] = SIDE_W'(i) < side;
		end
	end

	assign op_inside = (SIDE_W'(op.row) < side) && (SIDE_W'(op.col) < side);

	// Row look-ahead address during a generation step.
	assign la_addr = (SIDE_W + 1)'(rc_q) +
		(ctl.step_prime ? (SIDE_W + 1)'(1) : (SIDE_W + 1)'(2));

	// Read port address selection.
	assign rd_en = ctl.cell_read | ctl.step_start | ctl.step_prime | ctl.step_row;

	always_comb begin
		if (ctl.cell_read) begin
			rd_idx = IDX_W'(op.row);
			rd_in  = op_inside;
		end else if (ctl.step_start) begin
			rd_idx = '0;
			rd_in  = side != '0;
		end else begin
			rd_idx = la_addr[IDX_W-1:0];
			rd_in  = la_addr < (SIDE_W + 1)'(side);
		end
	end

	// Registered read of one memory row.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= cell_mem_q[rd_idx];
		end
	end

	// A row never written or outside the grid reads as all dead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_q <= 1'b0;
		end else if (rd_en) begin
			rd_ok_q <= row_vld_q[rd_idx] && rd_in;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_SIDE; i++) begin
			rd_live[i] = rd_ok_q && col_in[i] && rd_data_q[i][0];
		end
	end

	// Row window and row counter of the generation step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
		end else if (ctl.step_start) begin
			rc_q <= '0;
		end else if (ctl.step_row) begin
			rc_q <= rc_q + SIDE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step_start) begin
			prev_live_q <= '0;
		end else if (ctl.step_prime) begin
			cur_live_q <= rd_live;
		end else if (ctl.step_row) begin
			prev_live_q <= cur_live_q;
			cur_live_q  <= rd_live;
		end
		if (ctl.cell_read) begin
			col_q <= IDX_W'(op.col);
		end
	end

	// One lane per column: count the eight neighbors and apply the rule.
	always_comb begin
		logic [MAX_SIDE+1:0] up;
		logic [MAX_SIDE+1:0] mid;
		logic [MAX_SIDE+1:0] dn;
		logic [COUNT_W-1:0]  nbrs;
		up  = {1'b0, prev_live_q, 1'b0};
		mid = {1'b0, cur_live_q, 1'b0};
		dn  = {1'b0, rd_live, 1'b0};
		for (int i = 0; i < MAX_SIDE; i++) begin
			nbrs = COUNT_W'(up[i]) + COUNT_W'(up[i+1]) + COUNT_W'(up[i+2]) +
				COUNT_W'(mid[i]) + COUNT_W'(mid[i+2]) +
				COUNT_W'(dn[i]) + COUNT_W'(dn[i+1]) + COUNT_W'(dn[i+2]);
			new_row[i] = next_code(cur_live_q[i], nbrs, surv_a_q, surv_b_q, birth_q);
		end
	end

	// Write port: a single cell or a whole computed row.
	always_comb begin
		wr_data = '0;
		wr_mask = '0;
		if (ctl.step_row) begin
			wr_en  = 1'b1;
			wr_idx = rc_q[IDX_W-1:0];
			for (int i = 0; i < MAX_SIDE; i++) begin
				wr_data[i] = col_in[i] ? new_row[i] : CODE_DEAD;
			end
			wr_mask = col_in;
		end else begin
			wr_en  = ctl.cell_write && op_inside;
			wr_idx = IDX_W'(op.row);
			wr_data[IDX_W'(op.col)] = {1'b0, op.alive_in};
			wr_mask[IDX_W'(op.col)] = 1'b1;
		end
	end

	// The first write to a row stores every lane so stale contents are dropped.
	assign wr_full = !row_vld_q[wr_idx];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < MAX_SIDE; i++) begin
				if (wr_full || wr_mask[i]) begin
					cell_mem_q[wr_idx][i] <= wr_data[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[wr_idx] <= 1'b1;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			case (ctl.res_kind)
				RES_CODE: begin
					res_q.cell_code <= rd_ok_q ? rd_data_q[col_q] : CODE_DEAD;
					res_q.step_done <= 1'b0;
				end
				RES_DONE: begin
					res_q.cell_code <= CODE_DEAD;
					res_q.step_done <= 1'b1;
				end
				default: begin
					res_q.cell_code <= CODE_DEAD;
					res_q.step_done <= 1'b0;
				end
			endcase
		end
	end

	assign res = res_q;

	assign stat.side_zero = side == '0;
	assign stat.last_row  = (rc_q + SIDE_W'(1)) == side;

endmodule

// ===== rtl/lgs_ctrl.sv =====
`include "life_automaton_generation_step_defines.svh"

module lgs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	input  logic [1:0]     op_action,
	output logic           op_stall,
	output logic           res_valid,
	input  logic           res_stall,
	input  lgs_pkg::stat_t stat,
	output lgs_pkg::ctl_t  ctl
);
	import lgs_pkg::*;

	localparam logic [1:0] ST_IDLE       = 2'd0;
	localparam logic [1:0] ST_RD_WAIT    = 2'd1;
	localparam logic [1:0] ST_STEP_PRIME = 2'd2;
	localparam logic [1:0] ST_STEP_ROW   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       res_valid_q;
	logic       res_free;
	logic       accept;

	// A new request is taken only when idle and the output register can be refilled.
	assign res_free = !res_valid_q || !res_stall;
	assign accept   = op_valid && (state_q == ST_IDLE) && res_free;
	assign op_stall = !((state_q == ST_IDLE) && res_free);

	// Command decode and next state.
	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op_action)
						ACT_WRITE: begin
							ctl.cell_write = 1'b1;
							ctl.res_load   = 1'b1;
							ctl.res_kind   = RES_ZERO;
						end
						ACT_READ: begin
							ctl.cell_read = 1'b1;
							state_d       = ST_RD_WAIT;
						end
						ACT_STEP: begin
							if (stat.side_zero) begin
								ctl.res_load = 1'b1;
								ctl.res_kind = RES_DONE;
							end else begin
								ctl.step_start = 1'b1;
								state_d        = ST_STEP_PRIME;
							end
						end
						default: begin
							ctl.res_load = 1'b1;
							ctl.res_kind = RES_ZERO;
						end
					endcase
				end
			end
			ST_RD_WAIT: begin
				ctl.res_load = 1'b1;
				ctl.res_kind = RES_CODE;
				state_d      = ST_IDLE;
			end
			ST_STEP_PRIME: begin
				ctl.step_prime = 1'b1;
				state_d        = ST_STEP_ROW;
			end
			ST_STEP_ROW: begin
				ctl.step_row = 1'b1;
				if (stat.last_row) begin
					ctl.res_load = 1'b1;
					ctl.res_kind = RES_DONE;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;

	// A result is never loaded over one that is still waiting.
	`LGS_ASSERT_IMPL(a_no_res_overwrite, ctl.res_load, !(res_valid_q && res_stall))
	// The datapath gets at most one memory-access command per cycle.
	`LGS_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0({ctl.cell_write, ctl.cell_read, ctl.step_start, ctl.step_prime, ctl.step_row}))
	// A cell read loads its result into the output register in the following cycle.
	`LGS_ASSERT_NEXT(a_read_latency, accept && (op_action == ACT_READ), ctl.res_load && (ctl.res_kind == RES_CODE))
	// The last row of a step closes the step and returns to idle.
	`LGS_ASSERT_NEXT(a_step_end, (state_q == ST_STEP_ROW) && stat.last_row, (state_q == ST_IDLE) && res_valid_q)

endmodule

// ===== rtl/life_automaton_generation_step.sv =====
// Life cellular automaton on a square grid of up to 64 by 64 cells, each holding a two-bit
// code (dead, alive, died this step, born this step), with survive and birth counts set by
// registers. Requests write one cell, read one cell, or compute the next generation; each
// request returns exactly one result. A cell read passes through the registered read of
// the row memory. For a generation step the grid is kept as one memory row per grid row,
// and the step walks the rows one per cycle through the single read and write port of
// that memory while all columns of a row are worked out side by side. Each memory row has
// a valid flag that reset clears, so the grid reads as all dead right after reset with no
// clearing pass. Configuration writes are always ready and must only be issued while no
// request is in work.
module life_automaton_generation_step (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           op_valid,
	output logic                           op_stall,
	input  lgs_pkg::op_t                   op,
	output logic                           res_valid,
	input  logic                           res_stall,
	output lgs_pkg::res_t                  res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lgs_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	// Configuration registers accept a write in any cycle.
	assign cfg_ready = 1'b1;

	lgs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_action (op.action),
		.op_stall  (op_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	lgs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.stat      (stat),
		.res       (res)
	);

endmodule

// ===== sim/life_automaton_generation_step_test.sv =====
module life_automaton_generation_step_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lgs_pkg::*;

	// Action code that the block leaves unused.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam int CELL_TOTAL = MAX_SIDE * MAX_SIDE;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = MAX_SIDE + 8;
	localparam int RANDOM_ITEMS = 750;

	logic clk = 1'b0;
	logic arst_n;
	logic op_valid;
	logic op_stall;
	op_t op;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the grid and of the rule registers.
	logic [1:0] cell_model [CELL_TOTAL];
	logic [GRID_W-1:0] side_cfg;
	logic [COUNT_W-1:0] surv_a_cfg;
	logic [COUNT_W-1:0] surv_b_cfg;
	logic [COUNT_W-1:0] birth_cfg;

	// Results still owed by the block, oldest first.
	res_t pending_results [$];

	bit no_idle = 1'b0;
	int release_hold = 0;
	int failures = 0;
	int writes_sent = 0;
	int reads_sent = 0;
	int steps_sent = 0;
	int unused_sent = 0;
	int settings_written = 0;

	life_automaton_generation_step u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.op        (op),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Grid side actually in use; oversize values clamp to the memory size.
	function automatic int unsigned grid_in_use();
		return (side_cfg > MAX_SIDE) ? MAX_SIDE : side_cfg;
	endfunction

	function automatic bit code_is_live(input logic [1:0] code);
		return code == CODE_ALIVE || code == CODE_BORN;
	endfunction

	function automatic op_t make_op(input logic [1:0] action, input int unsigned row,
			input int unsigned col, input bit alive);
		op_t o;
		o.action = action;
		o.row = POS_W'(row);
		o.col = POS_W'(col);
		o.alive_in = alive;
		return o;
	endfunction

	// Compute the next generation of the shadow grid from a snapshot of the current one.
	task automatic advance_generation(input int unsigned side);
		logic [1:0] prev [CELL_TOTAL];
		int nbrs;
		int rr;
		int cc;
		int idx;
		prev = cell_model;
		for (int r = 0; r < side; r++) begin
			for (int c = 0; c < side; c++) begin
				nbrs = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						rr = r + dr;
						cc = c + dc;
						if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 &&
								rr < side && cc < side &&
								code_is_live(prev[rr * MAX_SIDE + cc])) begin
							nbrs++;
						end
					end
				end
				idx = r * MAX_SIDE + c;
				if (code_is_live(prev[idx])) begin
					cell_model[idx] = (nbrs == surv_a_cfg || nbrs == surv_b_cfg) ?
						CODE_ALIVE : CODE_DIED;
				end else begin
					cell_model[idx] = (nbrs == birth_cfg) ? CODE_BORN : CODE_DEAD;
				end
			end
		end
	endtask

	// Apply one accepted request to the shadow grid and queue the result it owes.
	task automatic predict_result(input op_t o);
		res_t r;
		int unsigned side;
		bit in_grid;
		int idx;
		r = '0;
		side = grid_in_use();
		in_grid = (o.row < side) && (o.col < side);
		idx = int'(o.row) * MAX_SIDE + int'(o.col);
		case (o.action)
			ACT_WRITE: begin
				writes_sent++;
				if (in_grid) begin
					cell_model[idx] = o.alive_in ? CODE_ALIVE : CODE_DEAD;
				end
			end
			ACT_READ: begin
				reads_sent++;
				if (in_grid) begin
					r.cell_code = cell_model[idx];
				end
			end
			ACT_STEP: begin
				steps_sent++;
				advance_generation(side);
				r.step_done = 1'b1;
			end
			default: begin
				unused_sent++;
			end
		endcase
		pending_results.push_back(r);
	endtask

	// Send one request after a random gap and wait until the block takes it.
	task automatic send_op(input op_t o);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_valid <= 1'b1;
		op <= o;
		do @(posedge clk); while (op_stall !== 1'b0);
		predict_result(o);
	endtask

	// Stop sending and wait until every owed result has come back.
	task automatic wait_idle();
		op_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Present one register write and wait for its handshake; valid stays high.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_GRID_SIDE: side_cfg = data[GRID_W-1:0];
			REG_SURVIVE_A: surv_a_cfg = data[COUNT_W-1:0];
			REG_SURVIVE_B: surv_b_cfg = data[COUNT_W-1:0];
			REG_BIRTH:     birth_cfg = data[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	// Rewrite all four registers while the block is idle.
	task automatic write_config(input logic [CFG_DATA_W-1:0] side_val,
			input logic [CFG_DATA_W-1:0] surv_a_val, input logic [CFG_DATA_W-1:0] surv_b_val,
			input logic [CFG_DATA_W-1:0] birth_val);
		wait_idle();
		put_reg(REG_GRID_SIDE, side_val);
		put_reg(REG_SURVIVE_A, surv_a_val);
		put_reg(REG_SURVIVE_B, surv_b_val);
		put_reg(REG_BIRTH, birth_val);
		cfg_valid <= 1'b0;
		settings_written++;
	endtask

	// A rule count that is mostly the usual one, sometimes any count, rarely one that never
	// matches; the upper data bits carry noise.
	function automatic logic [CFG_DATA_W-1:0] random_count(input int unsigned usual);
		logic [CFG_DATA_W-1:0] v;
		int unsigned k;
		v = CFG_DATA_W'($urandom_range(0, 127));
		k = $urandom_range(0, 9);
		if (k < 6) begin
			v[COUNT_W-1:0] = COUNT_W'(usual);
		end else if (k < 9) begin
			v[COUNT_W-1:0] = COUNT_W'($urandom_range(0, 8));
		end else begin
			v[COUNT_W-1:0] = COUNT_W'($urandom_range(9, 15));
		end
		return v;
	endfunction

	// Mostly requests inside the grid in use, with some anywhere in the field range.
	function automatic op_t random_op();
		op_t o;
		int unsigned side;
		int unsigned k;
		side = grid_in_use();
		k = $urandom_range(0, 99);
		if (k < 45) begin
			o.action = ACT_WRITE;
		end else if (k < 80) begin
			o.action = ACT_READ;
		end else if (k < 93) begin
			o.action = ACT_STEP;
		end else begin
			o.action = ACT_UNUSED;
		end
		if (side != 0 && $urandom_range(0, 9) < 8) begin
			o.row = POS_W'($urandom_range(0, side - 1));
			o.col = POS_W'($urandom_range(0, side - 1));
		end else begin
			o.row = POS_W'($urandom_range(0, MAX_SIDE - 1));
			o.col = POS_W'($urandom_range(0, MAX_SIDE - 1));
		end
		o.alive_in = ($urandom_range(0, 2) != 0);
		return o;
	endfunction

	// Cell writes and reads at the corners, right after reset, plus the unused action.
	task automatic test_cell_access();
		send_op(make_op(ACT_READ, MAX_SIDE - 1, MAX_SIDE - 1, 1'b0));
		send_op(make_op(ACT_WRITE, 0, 0, 1'b1));
		send_op(make_op(ACT_WRITE, MAX_SIDE - 1, MAX_SIDE - 1, 1'b1));
		send_op(make_op(ACT_WRITE, 0, MAX_SIDE - 1, 1'b1));
		send_op(make_op(ACT_WRITE, MAX_SIDE - 1, 0, 1'b1));
		send_op(make_op(ACT_READ, 0, 0, 1'b0));
		send_op(make_op(ACT_READ, MAX_SIDE - 1, MAX_SIDE - 1, 1'b1));
		send_op(make_op(ACT_WRITE, MAX_SIDE - 1, MAX_SIDE - 1, 1'b0));
		send_op(make_op(ACT_READ, MAX_SIDE - 1, MAX_SIDE - 1, 1'b0));
		send_op(make_op(ACT_UNUSED, MAX_SIDE - 1, MAX_SIDE - 1, 1'b1));
	endtask

	// A live pair on the left edge: both cells die, no birth beside them, with no wrap at the edges.
	task automatic test_generation_step();
		send_op(make_op(ACT_WRITE, 1, 0, 1'b1));
		send_op(make_op(ACT_WRITE, 2, 0, 1'b1));
		send_op(make_op(ACT_STEP, 0, 0, 1'b0));
		send_op(make_op(ACT_READ, 1, 0, 1'b0));
		send_op(make_op(ACT_READ, 2, 0, 1'b0));
		send_op(make_op(ACT_READ, 1, 1, 1'b0));
		send_op(make_op(ACT_STEP, 0, 0, 1'b0));
		send_op(make_op(ACT_READ, 0, MAX_SIDE - 1, 1'b0));
	endtask

	// Empty grid, clamped oversize grid, and a one-cell grid with extreme rule counts.
	task automatic test_grid_limits();
		write_config(0, 2, 3, 3);
		send_op(make_op(ACT_WRITE, 0, 0, 1'b1));
		send_op(make_op(ACT_READ, 0, 0, 1'b0));
		send_op(make_op(ACT_STEP, 0, 0, 1'b0));
		write_config(127, 2, 3, 3);
		send_op(make_op(ACT_READ, MAX_SIDE - 1, 0, 1'b0));
		write_config(1, 15, 8, 0);
		send_op(make_op(ACT_STEP, 0, 0, 1'b0));
		send_op(make_op(ACT_READ, 0, 0, 1'b0));
		send_op(make_op(ACT_READ, 1, 0, 1'b0));
	endtask

	// Phases of random requests, each under a fresh register setting.
	task automatic test_random_traffic(input int count);
		int stop_at;
		int unsigned k;
		logic [CFG_DATA_W-1:0] side_val;
		stop_at = writes_sent + reads_sent + steps_sent + unused_sent + count;
		while (writes_sent + reads_sent + steps_sent + unused_sent < stop_at) begin
			k = $urandom_range(0, 19);
			case (k)
				0: side_val = 0;
				1: side_val = CFG_DATA_W'(MAX_SIDE);
				2: side_val = CFG_DATA_W'($urandom_range(MAX_SIDE + 1, 127));
				3: side_val = CFG_DATA_W'($urandom_range(1, 2));
				default: side_val = CFG_DATA_W'($urandom_range(3, 16));
			endcase
			write_config(side_val, random_count(2), random_count(3), random_count(3));
			no_idle = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(20, 60)) send_op(random_op());
		end
		no_idle = 1'b0;
	endtask

	// Take results with random stalls and compare each with the oldest expectation.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: cell_code %0d, step_done %0d",
					res.cell_code, res.step_done);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (res.cell_code !== want.cell_code) begin
					$error("cell_code mismatch: expected %0d, actual %0d",
						want.cell_code, res.cell_code);
					failures++;
				end
				if (res.step_done !== want.step_done) begin
					$error("step_done mismatch: expected %0d, actual %0d",
						want.step_done, res.step_done);
					failures++;
				end
			end
			release_hold = no_idle ? 0 : $urandom_range(0, 3);
		end else if (release_hold != 0) begin
			release_hold--;
		end
		res_stall <= (release_hold != 0);
	end

	// End the run when no handshake of any kind happens for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (op_valid === 1'b1 && op_stall === 1'b0) ||
					(res_valid === 1'b1 && res_stall === 1'b0) ||
					(cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		op_valid = 1'b0;
		op = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		foreach (cell_model[i]) cell_model[i] = CODE_DEAD;
		side_cfg = GRID_W'(MAX_SIDE);
		surv_a_cfg = 2;
		surv_b_cfg = 3;
		birth_cfg = 3;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_cell_access();
		test_generation_step();
		test_grid_limits();
		test_random_traffic(RANDOM_ITEMS);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d cell writes, %0d cell reads, %0d generation steps, %0d unused",
			writes_sent, reads_sent, steps_sent, unused_sent);
		$display("requests across %0d register settings, from an empty grid to clamped oversize.",
			settings_written);
		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
